// File: hdl/spc_pkg.sv
// Shared types, widths and constants for the shape pair collision test.
// No dependencies; imported by every module of the block.
package spc_pkg;

  localparam int CoordW = 24;
  localparam int ExtW   = 21;
  localparam int DiffW  = CoordW + 2;
  localparam int SqW    = 2 * DiffW;
  localparam int RootW  = SqW / 2;
  localparam int NormW  = 16;
  localparam int QuoW   = 15;
  localparam int FracQ  = 14;
  localparam int NumW   = DiffW + FracQ + 1;
  localparam int BaseW  = ExtW + 2;
  localparam int P2W    = BaseW + 2;
  localparam int PenW   = 23;

  localparam int GeomStages = 4;
  localparam int SqrtStages = RootW;
  localparam int DivStages  = QuoW;

  localparam logic ShapeCircle = 1'b0;
  localparam logic ShapeBox    = 1'b1;

  localparam logic signed [NormW-1:0] UnitQ14 = 16'sd16384;
  localparam logic [PenW-1:0]         PenMax  = 23'd8388607;

  typedef struct packed {
    logic                     a_shape;
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic [ExtW-1:0]          a_width;
    logic [ExtW-1:0]          a_height;
    logic [ExtW-1:0]          a_radius;
    logic                     b_shape;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic [ExtW-1:0]          b_width;
    logic [ExtW-1:0]          b_height;
    logic [ExtW-1:0]          b_radius;
  } spc_req_t;

  typedef struct packed {
    logic                    colliding;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic [PenW-1:0]         penetration;
  } spc_rsp_t;

  typedef struct packed {
    logic                    hit;
    logic                    use_d;
    logic                    cc;
    logic                    flip;
    logic                    add_d;
    logic signed [DiffW-1:0] vx;
    logic signed [DiffW-1:0] vy;
    logic [BaseW-1:0]        base;
    logic [BaseW-1:0]        alt_p;
    logic signed [NormW-1:0] bnx;
    logic signed [NormW-1:0] bny;
  } spc_ctx_t;

  function automatic logic [DiffW-1:0] abs_d(input logic signed [DiffW-1:0] v);
    abs_d = v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
  endfunction

endpackage

// File: hdl/spc_geom.sv
// Front stages: offsets, box overlap, circle clamp, squares and hit test.
// Depends on spc_pkg.
module spc_geom
  import spc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  spc_req_t   req_i,
  output logic       out_valid_o,
  output spc_ctx_t   ctx_o,
  output logic [SqW-1:0] dsq_o
);

  // stage 1
  logic                    s1_vld_q;
  logic                    s1_abox_q, s1_bbox_q;
  logic signed [DiffW-1:0] s1_dx_q, s1_dy_q, s1_qx_q, s1_qy_q;
  logic [ExtW-1:0]         s1_ex_q, s1_ey_q;
  logic [ExtW:0]           s1_swx_q, s1_swy_q;
  logic [BaseW-1:0]        s1_rs_q, s1_ar_q, s1_r_q;

  logic signed [DiffW-1:0] ax_w, ay_w, bx_w, by_w;
  logic                    cisa_in;

  assign ax_w    = DiffW'($signed({req_i.a_x, 1'b0}));
  assign ay_w    = DiffW'($signed({req_i.a_y, 1'b0}));
  assign bx_w    = DiffW'($signed({req_i.b_x, 1'b0}));
  assign by_w    = DiffW'($signed({req_i.b_y, 1'b0}));
  assign cisa_in = (req_i.a_shape == ShapeCircle);

  always_ff @(posedge clk_i) begin
    s1_abox_q <= (req_i.a_shape == ShapeBox);
    s1_bbox_q <= (req_i.b_shape == ShapeBox);
    s1_dx_q   <= bx_w - ax_w;
    s1_dy_q   <= by_w - ay_w;
    s1_qx_q   <= cisa_in ? ax_w - bx_w : bx_w - ax_w;
    s1_qy_q   <= cisa_in ? ay_w - by_w : by_w - ay_w;
    s1_ex_q   <= cisa_in ? req_i.b_width : req_i.a_width;
    s1_ey_q   <= cisa_in ? req_i.b_height : req_i.a_height;
    s1_swx_q  <= (ExtW+1)'(req_i.a_width) + (ExtW+1)'(req_i.b_width);
    s1_swy_q  <= (ExtW+1)'(req_i.a_height) + (ExtW+1)'(req_i.b_height);
    s1_rs_q   <= BaseW'({req_i.a_radius, 1'b0}) + BaseW'({req_i.b_radius, 1'b0});
    s1_ar_q   <= BaseW'({req_i.a_radius, 1'b0});
    s1_r_q    <= cisa_in ? BaseW'({req_i.a_radius, 1'b0}) : BaseW'({req_i.b_radius, 1'b0});
  end

  // stage 2
  logic                    s2_vld_q;
  spc_ctx_t                s2_ctx_q;
  spc_ctx_t                s2_ctx_d;
  logic signed [DiffW-1:0] ex_s, ey_s, px, py;
  logic signed [DiffW:0]   ox, oy;
  logic                    lo_x, hi_x, lo_y, hi_y, in_box, cisa;

  always_comb begin
    ex_s   = $signed(DiffW'(s1_ex_q));
    ey_s   = $signed(DiffW'(s1_ey_q));
    ox     = $signed((DiffW+1)'(s1_swx_q)) - $signed((DiffW+1)'(abs_d(s1_dx_q)));
    oy     = $signed((DiffW+1)'(s1_swy_q)) - $signed((DiffW+1)'(abs_d(s1_dy_q)));
    cisa   = !s1_abox_q;
    lo_x   = s1_qx_q < -ex_s;
    hi_x   = s1_qx_q > ex_s;
    lo_y   = s1_qy_q < -ey_s;
    hi_y   = s1_qy_q > ey_s;
    in_box = !lo_x && !hi_x && !lo_y && !hi_y;
    px     = lo_x ? -ex_s : (hi_x ? ex_s : s1_qx_q);
    py     = lo_y ? -ey_s : (hi_y ? ey_s : s1_qy_q);
    if (in_box) begin
      if (abs_d(s1_qx_q) > abs_d(s1_qy_q)) begin
        px = (s1_qx_q > 0) ? ex_s : -ex_s;
      end else begin
        py = (s1_qy_q > 0) ? ey_s : -ey_s;
      end
    end
    s2_ctx_d = '0;
    if (s1_abox_q && s1_bbox_q) begin
      s2_ctx_d.hit = (ox > 0) && (oy > 0);
      if (ox < oy) begin
        s2_ctx_d.bnx   = s1_dx_q[DiffW-1] ? -UnitQ14 : UnitQ14;
        s2_ctx_d.alt_p = ox[BaseW-1:0];
      end else begin
        s2_ctx_d.bny   = s1_dy_q[DiffW-1] ? -UnitQ14 : UnitQ14;
        s2_ctx_d.alt_p = oy[BaseW-1:0];
      end
    end else if (!s1_abox_q && !s1_bbox_q) begin
      s2_ctx_d.use_d = 1'b1;
      s2_ctx_d.cc    = 1'b1;
      s2_ctx_d.vx    = s1_dx_q;
      s2_ctx_d.vy    = s1_dy_q;
      s2_ctx_d.base  = s1_rs_q;
      s2_ctx_d.alt_p = s1_ar_q;
    end else begin
      s2_ctx_d.use_d = 1'b1;
      s2_ctx_d.flip  = cisa ^ in_box;
      s2_ctx_d.add_d = in_box;
      s2_ctx_d.vx    = s1_qx_q - px;
      s2_ctx_d.vy    = s1_qy_q - py;
      s2_ctx_d.base  = s1_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ctx_q <= s2_ctx_d;
  end

  // stage 3
  logic                  s3_vld_q;
  spc_ctx_t              s3_ctx_q;
  logic [SqW-1:0]        s3_sqx_q, s3_sqy_q;
  logic [2*BaseW-1:0]    s3_bsq_q;
  logic [DiffW-1:0]      avx, avy;

  assign avx = abs_d(s2_ctx_q.vx);
  assign avy = abs_d(s2_ctx_q.vy);

  always_ff @(posedge clk_i) begin
    s3_ctx_q <= s2_ctx_q;
    s3_sqx_q <= avx * avx;
    s3_sqy_q <= avy * avy;
    s3_bsq_q <= s2_ctx_q.base * s2_ctx_q.base;
  end

  // stage 4
  logic           s4_vld_q;
  spc_ctx_t       s4_ctx_q;
  spc_ctx_t       s4_ctx_d;
  logic [SqW-1:0] s4_dsq_q, dsq;

  always_comb begin
    dsq      = s3_sqx_q + s3_sqy_q;
    s4_ctx_d = s3_ctx_q;
    if (s3_ctx_q.use_d) begin
      s4_ctx_d.hit = s3_ctx_q.add_d || (dsq <= SqW'(s3_bsq_q));
    end
  end

  always_ff @(posedge clk_i) begin
    s4_ctx_q <= s4_ctx_d;
    s4_dsq_q <= dsq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  assign out_valid_o = s4_vld_q;
  assign ctx_o       = s4_ctx_q;
  assign dsq_o       = s4_dsq_q;

endmodule

// File: hdl/spc_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on spc_pkg.
module spc_sqrt
  import spc_pkg::*;
(
  input  logic             clk_i,
  input  logic [SqW-1:0]   rad_i,
  output logic [RootW-1:0] root_o
);

  logic [SqW-1:0]   rem_q  [SqrtStages];
  logic [RootW-1:0] root_q [SqrtStages];

  for (genvar i = 0; i < SqrtStages; i++) begin : g_stage
    localparam int K = RootW - 1 - i;
    logic [SqW-1:0]   rem_in, rem_d;
    logic [RootW-1:0] root_in, root_d;
    logic [SqW:0]     trial;

    if (i == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    always_comb begin
      trial  = ((SqW+1)'(root_in) << (K + 1)) + ((SqW+1)'(1) << (2 * K));
      rem_d  = rem_in;
      root_d = root_in;
      if ({1'b0, rem_in} >= trial) begin
        rem_d  = rem_in - trial[SqW-1:0];
        root_d = root_in | (RootW'(1) << K);
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= rem_d;
      root_q[i] <= root_d;
    end
  end

  assign root_o = root_q[SqrtStages-1];

endmodule

// File: hdl/spc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on spc_pkg.
module spc_div
  import spc_pkg::*;
(
  input  logic             clk_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [RootW-1:0] den_i,
  output logic [QuoW-1:0]  quo_o
);

  logic [NumW-1:0]  rem_q [DivStages];
  logic [RootW-1:0] den_q [DivStages];
  logic [QuoW-1:0]  quo_q [DivStages];

  for (genvar i = 0; i < DivStages; i++) begin : g_stage
    localparam int K = QuoW - 1 - i;
    logic [NumW-1:0]  rem_in, rem_d, sub;
    logic [RootW-1:0] den_in;
    logic [QuoW-1:0]  quo_in, quo_d;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    always_comb begin
      sub   = NumW'(den_in) << K;
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= sub) begin
        rem_d = rem_in - sub;
        quo_d = quo_in | (QuoW'(1) << K);
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= rem_d;
      den_q[i] <= den_in;
      quo_q[i] <= quo_d;
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

// File: hdl/shape_pair_collision_test.sv
// Top level of the shape pair collision test: geometry, square root, normal divide.
// Depends on spc_pkg, spc_geom, spc_sqrt and spc_div.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-----------------------
//   request   | start in, busy out   | req_i  (spc_req_t)
//   result    | done_o strobe out    | rsp_o  (spc_rsp_t)
//
// One request per cycle; busy stays low. Each result passes through 4 geometry
// stages, 26 square root stages, 15 divide stages and 1 output register.
// Latency is set by the bit-per-stage root and quotient pipelines.
// Reset clears only the valid bits; results are never held back.
module shape_pair_collision_test
  import spc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  spc_req_t req_i,
  output logic     done_o,
  output spc_rsp_t rsp_o
);

  localparam int Latency = GeomStages + SqrtStages + DivStages + 1;

  logic           g_vld;
  spc_ctx_t       g_ctx;
  logic [SqW-1:0] g_dsq;

  assign busy = 1'b0;

  spc_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start && !busy),
    .req_i       (req_i),
    .out_valid_o (g_vld),
    .ctx_o       (g_ctx),
    .dsq_o       (g_dsq)
  );

  logic [RootW-1:0] root;

  spc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (g_dsq),
    .root_o (root)
  );

  spc_ctx_t              ctx_s_q [SqrtStages];
  logic [SqrtStages-1:0] vld_s_q;

  always_ff @(posedge clk_i) begin
    ctx_s_q[0] <= g_ctx;
    for (int i = 1; i < SqrtStages; i++) begin
      ctx_s_q[i] <= ctx_s_q[i-1];
    end
  end

  spc_ctx_t         ctx_r;
  logic [NumW-1:0]  num_x, num_y;
  logic [QuoW-1:0]  quo_x, quo_y;

  assign ctx_r = ctx_s_q[SqrtStages-1];
  assign num_x = {NumW'(abs_d(ctx_r.vx)) << FracQ} + NumW'(root >> 1);
  assign num_y = {NumW'(abs_d(ctx_r.vy)) << FracQ} + NumW'(root >> 1);

  spc_div u_div_x (
    .clk_i (clk_i),
    .num_i (num_x),
    .den_i (root),
    .quo_o (quo_x)
  );

  spc_div u_div_y (
    .clk_i (clk_i),
    .num_i (num_y),
    .den_i (root),
    .quo_o (quo_y)
  );

  spc_ctx_t             ctx_v_q [DivStages];
  logic [RootW-1:0]     d_v_q   [DivStages];
  logic [DivStages-1:0] vld_v_q;

  always_ff @(posedge clk_i) begin
    ctx_v_q[0] <= ctx_r;
    d_v_q[0]   <= root;
    for (int i = 1; i < DivStages; i++) begin
      ctx_v_q[i] <= ctx_v_q[i-1];
      d_v_q[i]   <= d_v_q[i-1];
    end
  end

  spc_ctx_t                ctx_f;
  logic [RootW-1:0]        d_f;
  logic signed [NormW-1:0] mag_x, mag_y;
  logic [P2W-1:0]          p2;
  logic [P2W:0]            p2_inc;
  logic [P2W-1:0]          pen_full;
  spc_rsp_t                rsp_d, rsp_q;
  logic                    done_q;

  always_comb begin
    ctx_f    = ctx_v_q[DivStages-1];
    d_f      = d_v_q[DivStages-1];
    mag_x    = $signed(NormW'(quo_x));
    mag_y    = $signed(NormW'(quo_y));
    p2       = '0;
    rsp_d    = '0;
    if (!ctx_f.use_d) begin
      rsp_d.normal_x = ctx_f.bnx;
      rsp_d.normal_y = ctx_f.bny;
      p2             = P2W'(ctx_f.alt_p);
    end else if (d_f == '0) begin
      rsp_d.normal_x = ctx_f.cc ? UnitQ14 : '0;
      p2             = ctx_f.cc ? P2W'(ctx_f.alt_p) : P2W'(ctx_f.base);
    end else begin
      rsp_d.normal_x = (ctx_f.vx[DiffW-1] ^ ctx_f.flip) ? -mag_x : mag_x;
      rsp_d.normal_y = (ctx_f.vy[DiffW-1] ^ ctx_f.flip) ? -mag_y : mag_y;
      p2 = ctx_f.add_d ? P2W'(ctx_f.base) + P2W'(d_f) : P2W'(ctx_f.base) - P2W'(d_f);
    end
    p2_inc   = (P2W+1)'(p2) + (P2W+1)'(1);
    pen_full = p2_inc[P2W:1];
    rsp_d.penetration = (pen_full > P2W'(PenMax)) ? PenMax : pen_full[PenW-1:0];
    rsp_d.colliding   = ctx_f.hit;
    if (!ctx_f.hit) begin
      rsp_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s_q <= '0;
      vld_v_q <= '0;
      done_q  <= 1'b0;
    end else begin
      vld_s_q <= {vld_s_q[SqrtStages-2:0], g_vld};
      vld_v_q <= {vld_v_q[DivStages-2:0], vld_s_q[SqrtStages-1]};
      done_q  <= vld_v_q[DivStages-1];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result strobe without matching request");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.colliding |->
      rsp_o.normal_x == '0 && rsp_o.normal_y == '0 && rsp_o.penetration == '0)
    else $error("non-colliding result carries normal or depth");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.normal_x >= -UnitQ14 && rsp_o.normal_x <= UnitQ14 &&
               rsp_o.normal_y >= -UnitQ14 && rsp_o.normal_y <= UnitQ14)
    else $error("normal component out of unit range");

endmodule

// File: test/spc_contact_checker.sv
// Checker for the shape pair collision test: predicts each contact result from
// the accepted request and compares it with the result strobe.
// Depends on spc_pkg.
module spc_contact_checker
  import spc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  spc_req_t req_i,
  input  logic     done_o,
  input  spc_rsp_t rsp_o,
  output int       fail_count_o,
  output int       pending_o
);

  spc_rsp_t expected_contacts[$];
  int       fail_count = 0;
  int       pending_n = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_n;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint unit_comp(longint c, longint unsigned d);
    longint unsigned mag;
    longint unsigned quo;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    quo = (mag * 16384 + d / 2) / d;
    return (c < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint absv(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic spc_rsp_t predict_contact(spc_req_t r);
    spc_rsp_t        res;
    logic            a_box, b_box, hit, in_box, circle_a;
    longint          ax, ay, aw, ah, ar, bx, by, bw, bh, br;
    longint          dx, dy, ox, oy, nx, ny;
    longint          cx, cy, kx, ky, ex, ey, rad, qx, qy, px, py, vx, vy;
    longint unsigned p2, dsq, rs, d, pen;
    a_box = (r.a_shape == ShapeBox);
    b_box = (r.b_shape == ShapeBox);
    ax = 2 * longint'($signed(r.a_x));
    ay = 2 * longint'($signed(r.a_y));
    bx = 2 * longint'($signed(r.b_x));
    by = 2 * longint'($signed(r.b_y));
    aw = longint'(r.a_width);
    ah = longint'(r.a_height);
    bw = longint'(r.b_width);
    bh = longint'(r.b_height);
    ar = 2 * longint'(r.a_radius);
    br = 2 * longint'(r.b_radius);
    hit = 1'b0;
    nx = 0;
    ny = 0;
    p2 = 0;
    if (a_box && b_box) begin
      dx = bx - ax;
      dy = by - ay;
      ox = aw + bw - absv(dx);
      oy = ah + bh - absv(dy);
      if (ox > 0 && oy > 0) begin
        hit = 1'b1;
        if (ox < oy) begin
          nx = (dx < 0) ? -16384 : 16384;
          p2 = ox;
        end else begin
          ny = (dy < 0) ? -16384 : 16384;
          p2 = oy;
        end
      end
    end else if (!a_box && !b_box) begin
      dx  = bx - ax;
      dy  = by - ay;
      dsq = longint'(dx * dx) + longint'(dy * dy);
      rs  = ar + br;
      if (dsq <= rs * rs) begin
        d   = int_sqrt(dsq);
        hit = 1'b1;
        if (d != 0) begin
          p2 = rs - d;
          nx = unit_comp(dx, d);
          ny = unit_comp(dy, d);
        end else begin
          p2 = ar;
          nx = 16384;
        end
      end
    end else begin
      circle_a = !a_box;
      cx  = circle_a ? ax : bx;
      cy  = circle_a ? ay : by;
      kx  = circle_a ? bx : ax;
      ky  = circle_a ? by : ay;
      ex  = circle_a ? bw : aw;
      ey  = circle_a ? bh : ah;
      rad = circle_a ? ar : br;
      qx  = cx - kx;
      qy  = cy - ky;
      px  = clampv(qx, -ex, ex);
      py  = clampv(qy, -ey, ey);
      in_box = (qx == px) && (qy == py);
      if (in_box) begin
        if (absv(qx) > absv(qy)) px = (px > 0) ? ex : -ex;
        else py = (py > 0) ? ey : -ey;
      end
      vx  = qx - px;
      vy  = qy - py;
      dsq = longint'(vx * vx) + longint'(vy * vy);
      if (in_box || dsq <= longint'(rad * rad)) begin
        d   = int_sqrt(dsq);
        hit = 1'b1;
        if (d != 0) begin
          nx = unit_comp(vx, d);
          ny = unit_comp(vy, d);
          if (circle_a) begin
            nx = -nx;
            ny = -ny;
          end
          if (in_box) begin
            nx = -nx;
            ny = -ny;
          end
        end
        p2 = in_box ? rad + d : rad - d;
      end
    end
    pen = (p2 + 1) >> 1;
    if (pen > 8388607) pen = 8388607;
    res.colliding   = hit;
    res.normal_x    = hit ? NormW'(nx) : '0;
    res.normal_y    = hit ? NormW'(ny) : '0;
    res.penetration = hit ? PenW'(pen) : '0;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    spc_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_contacts.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_contacts.pop_front();
          if (rsp_o.colliding !== want.colliding)
            report_mismatch("colliding", rsp_o.colliding, want.colliding);
          if (rsp_o.normal_x !== want.normal_x)
            report_mismatch("normal_x", rsp_o.normal_x, want.normal_x);
          if (rsp_o.normal_y !== want.normal_y)
            report_mismatch("normal_y", rsp_o.normal_y, want.normal_y);
          if (rsp_o.penetration !== want.penetration)
            report_mismatch("penetration", rsp_o.penetration, want.penetration);
        end
      end
      if (start && !busy) expected_contacts = {expected_contacts, predict_contact(req_i)};
      pending_n = expected_contacts.size();
    end
  end

endmodule

// File: test/testbench.sv
// Top of the shape pair collision test bench: clock, reset, request stimulus
// and verdict. Depends on spc_pkg, spc_contact_checker and the block itself.
module testbench;
  import spc_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spc_req_t req_i = '0;
  logic     done_o;
  spc_rsp_t rsp_o;
  int       fail_count;
  int       pending;
  int       cycle_count = 0;
  int       idle_pct = 30;

  localparam int CycleLimit = 40000;

  always #5 clk_i = ~clk_i;

  shape_pair_collision_test dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o
  );

  spc_contact_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic spc_req_t make_pair(logic as, int ax, int ay, int aw, int ah, int ar,
                                         logic bs, int bx, int by, int bw, int bh, int br);
    spc_req_t r;
    r.a_shape  = as;
    r.a_x      = CoordW'(ax);
    r.a_y      = CoordW'(ay);
    r.a_width  = ExtW'(aw);
    r.a_height = ExtW'(ah);
    r.a_radius = ExtW'(ar);
    r.b_shape  = bs;
    r.b_x      = CoordW'(bx);
    r.b_y      = CoordW'(by);
    r.b_width  = ExtW'(bw);
    r.b_height = ExtW'(bh);
    r.b_radius = ExtW'(br);
    return r;
  endfunction

  function automatic int near_offset(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic spc_req_t random_pair();
    spc_req_t r;
    int       span;
    r = spc_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 99) < 80) begin
      span = 1 << $urandom_range(3, 20);
      r.a_width  = ExtW'($urandom_range(0, span));
      r.a_height = ExtW'($urandom_range(0, span));
      r.a_radius = ExtW'($urandom_range(0, span));
      r.b_width  = ExtW'($urandom_range(0, span));
      r.b_height = ExtW'($urandom_range(0, span));
      r.b_radius = ExtW'($urandom_range(0, span));
      r.b_x = r.a_x + CoordW'(near_offset(2 * span));
      r.b_y = r.a_y + CoordW'(near_offset(2 * span));
      if ($urandom_range(0, 9) == 0) r.b_x = r.a_x;
      if ($urandom_range(0, 9) == 0) r.b_y = r.a_y;
    end
    return r;
  endfunction

  task automatic send_request(spc_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
  endtask

  initial begin
    spc_req_t directed[$];
    directed = {directed, make_pair(ShapeBox, 0, 0, 100, 200, 0, ShapeBox, 150, 10, 100, 200, 0)};
    directed = {directed, make_pair(ShapeBox, 0, 0, 200, 100, 0,
                                    ShapeBox, -10, -150, 200, 100, 0)};
    directed = {directed, make_pair(ShapeBox, 0, 0, 100, 100, 0, ShapeBox, 50, 50, 100, 100, 0)};
    directed = {directed, make_pair(ShapeBox, 0, 0, 100, 100, 0, ShapeBox, 100, 0, 100, 100, 0)};
    directed = {directed, make_pair(ShapeBox, 5, 5, 100, 300, 0, ShapeBox, 5, 5, 100, 300, 0)};
    directed = {directed, make_pair(ShapeBox, 5, 5, 300, 100, 0, ShapeBox, 5, 5, 300, 100, 0)};
    directed = {directed, make_pair(ShapeCircle, 0, 0, 0, 0, 100,
                                    ShapeCircle, 30, 40, 0, 0, 50)};
    directed = {directed, make_pair(ShapeCircle, 0, 0, 0, 0, 30,
                                    ShapeCircle, 60, 80, 0, 0, 70)};
    directed = {directed, make_pair(ShapeCircle, 0, 0, 0, 0, 30,
                                    ShapeCircle, 60, 80, 0, 0, 60)};
    directed = {directed, make_pair(ShapeCircle, 7, -9, 0, 0, 77,
                                    ShapeCircle, 7, -9, 0, 0, 20)};
    directed = {directed, make_pair(ShapeCircle, 0, 0, 0, 0, 0, ShapeCircle, 0, 0, 0, 0, 0)};
    directed = {directed, make_pair(ShapeCircle, 300, 20, 0, 0, 50,
                                    ShapeBox, 0, 0, 200, 200, 0)};
    directed = {directed, make_pair(ShapeBox, 0, 0, 200, 200, 0,
                                    ShapeCircle, 300, 20, 0, 0, 50)};
    directed = {directed, make_pair(ShapeCircle, 50, 10, 0, 0, 30,
                                    ShapeBox, 0, 0, 200, 200, 0)};
    directed = {directed, make_pair(ShapeBox, 0, 0, 200, 200, 0,
                                    ShapeCircle, -30, -30, 0, 0, 30)};
    directed = {directed, make_pair(ShapeCircle, 0, 0, 0, 0, 40,
                                    ShapeBox, 0, 0, 200, 100, 0)};
    directed = {directed, make_pair(ShapeCircle, 3, 3, 0, 0, 40, ShapeBox, 3, 3, 0, 0, 0)};
    directed = {directed, make_pair(ShapeCircle, 500, 500, 0, 0, 10,
                                    ShapeBox, 0, 0, 100, 100, 0)};
    directed = {directed, make_pair(ShapeBox, 8388607, 8388607, 2097151, 2097151, 2097151,
                                    ShapeBox, -8388608, -8388608, 2097151, 2097151, 2097151)};
    directed = {directed, make_pair(ShapeCircle, 8388607, -8388608, 2097151, 2097151, 2097151,
                                    ShapeCircle, -8388608, 8388607, 2097151, 2097151, 2097151)};
    directed = {directed, make_pair(ShapeCircle, -8388608, 0, 0, 0, 2097151,
                                    ShapeBox, 8388607, 0, 2097151, 2097151, 0)};
    directed = {directed, make_pair(ShapeBox, 0, 0, 2097151, 2097151, 0,
                                    ShapeBox, 0, 1, 2097151, 2097151, 0)};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 30;
    foreach (directed[i]) send_request(directed[i]);
    repeat (130) send_request(random_pair());
    idle_pct = 71;
    repeat (150) send_request(random_pair());
    idle_pct = 0;
    repeat (150) send_request(random_pair());
    start <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: shape_pair_collision_test.f
hdl/spc_pkg.sv
hdl/spc_geom.sv
hdl/spc_sqrt.sv
hdl/spc_div.sv
hdl/shape_pair_collision_test.sv
test/spc_contact_checker.sv
test/testbench.sv
